FILE: hw/rtl/prfs_pkg.sv
// Shared types and constants for the PNG row filter selector.
// Used by prfs_ctrl, prfs_dp and png_row_filter_selector.
`timescale 1ns / 1ps
`default_nettype none
package prfs_pkg;
    localparam int MAX_ROW_BYTES = 4096;
    localparam int MAX_BPP = 8;
    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int PW = AW + 1;
    localparam int SUM_W = 20;
    localparam int NUM_FILTERS = 5;
    localparam logic [PW-1:0] RB_RESET = PW'(MAX_ROW_BYTES);
    localparam logic [3:0] BPP_RESET = 4'd1;
    localparam logic [15:0] THR_RESET = 16'd600;

    localparam logic [1:0] CFG_ROW_BYTES = 2'd0;
    localparam logic [1:0] CFG_BPP = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [2:0] F_NONE = 3'd0;
    localparam logic [2:0] F_SUB = 3'd1;
    localparam logic [2:0] F_UP = 3'd2;
    localparam logic [2:0] F_AVG = 3'd3;
    localparam logic [2:0] F_PAETH = 3'd4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PICK
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic pick;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic row_done;
    } t_stat;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [8:0] pa;
        logic [8:0] pb;
        logic [9:0] pc;
        logic signed [10:0] t;
        pa = (b >= c) ? 9'(b - c) : 9'(c - b);
        pb = (a >= c) ? 9'(a - c) : 9'(c - a);
        t = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c})
            - $signed({3'b000, c});
        pc = (t < 0) ? 10'(-t) : 10'(t);
        if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
            return a;
        end else if ({1'b0, pb} <= pc) begin
            return b;
        end
        return c;
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/prfs_ctrl.sv
// Controller state machine: sequences load, execute and filter pick.
// Depends on prfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prfs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  prfs_pkg::t_stat     i_stat,
    output logic                o_in_ready,
    output prfs_pkg::t_cmd      o_cmd
);
    import prfs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_stat.out_free) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_stat.row_done ? ST_PICK : ST_IDLE;
            end
            ST_PICK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_stat.out_free;
                o_cmd.load = i_in_valid && i_stat.out_free;
            end
            ST_EXEC: o_cmd.exec = 1'b1;
            ST_PICK: o_cmd.pick = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    a_pick_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK) |-> $past(r_state) == ST_EXEC)
        else $error("pick without execute");
    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EXEC))
        else $error("load not followed by execute");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("ready outside idle");
endmodule
`default_nettype wire

FILE: hw/rtl/prfs_dp.sv
// Datapath: row stores (two swapped banks), candidate sums, positions, output beat.
// Depends on prfs_pkg; driven by prfs_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module prfs_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  prfs_pkg::t_cmd      i_cmd,
    input  wire logic           i_op,
    input  wire logic [7:0]     i_data,
    input  wire logic           i_new,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_addr,
    input  wire logic [15:0]    i_cfg_wdata,
    input  wire logic           i_out_ready,
    output prfs_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic [2:0]          o_out_flags,
    output logic                o_out_last
);
    import prfs_pkg::*;

    logic [7:0] r_mem0 [MAX_ROW_BYTES];
    logic [7:0] r_mem1 [MAX_ROW_BYTES];

    logic [PW-1:0] r_row_bytes;
    logic [3:0] r_bpp;
    logic [15:0] r_thr;
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [SUM_W-1:0] r_sum [NUM_FILTERS];
    logic [SUM_W-1:0] n_sum [NUM_FILTERS];
    logic [2:0] r_chosen;
    logic r_row_ready;
    logic r_first;
    logic r_bank;
    logic r_op, r_data_new;
    logic [7:0] r_data;
    logic [AW-1:0] r_pos;
    logic r_has_left;
    logic [7:0] r_rd0a, r_rd0b, r_rd1a, r_rd1b;
    logic r_o_valid;
    logic [7:0] r_o_byte;
    logic [2:0] r_o_flags;
    logic r_o_last;

    logic [PW-1:0] len;
    logic [3:0] bpp;
    logic [AW-1:0] addr_a, addr_b;
    logic [7:0] x, a, b, c;
    logic [7:0] res [NUM_FILTERS];
    logic [PW-1:0] wp_next;
    logic push_ok;
    logic [2:0] best;

    always_comb begin
        len = r_row_bytes;
        if (r_row_bytes == '0) len = PW'(1);
        if (r_row_bytes > PW'(MAX_ROW_BYTES)) len = PW'(MAX_ROW_BYTES);
        bpp = r_bpp;
        if (r_bpp == 4'd0) bpp = 4'd1;
        if (r_bpp > 4'(MAX_BPP)) bpp = 4'(MAX_BPP);
    end

    always_comb begin
        if (i_op == OP_PUSH) begin
            if (i_new) begin
                addr_a = '0;
            end else if (r_wp >= PW'(MAX_ROW_BYTES)) begin
                addr_a = AW'(MAX_ROW_BYTES - 1);
            end else begin
                addr_a = r_wp[AW-1:0];
            end
        end else begin
            addr_a = AW'(r_rp - PW'(1));
        end
        addr_b = addr_a - AW'(bpp);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd0a <= r_mem0[addr_a];
            r_rd0b <= r_mem0[addr_b];
        end
        if (i_cmd.exec && push_ok && !r_bank) r_mem0[r_pos] <= r_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd1a <= r_mem1[addr_a];
            r_rd1b <= r_mem1[addr_b];
        end
        if (i_cmd.exec && push_ok && r_bank) r_mem1[r_pos] <= r_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_data <= i_data;
            r_data_new <= i_new;
            r_pos <= addr_a;
            r_has_left <= {{(PW-AW){1'b0}}, addr_a} >= PW'(bpp);
        end
    end

    always_comb begin
        x = (r_op == OP_PUSH) ? r_data : (r_bank ? r_rd1a : r_rd0a);
        a = r_has_left ? (r_bank ? r_rd1b : r_rd0b) : 8'd0;
        b = r_bank ? r_rd0a : r_rd1a;
        c = r_has_left ? (r_bank ? r_rd0b : r_rd1b) : 8'd0;
        res[F_NONE] = x;
        res[F_SUB] = x - a;
        res[F_UP] = x - b;
        res[F_AVG] = x - 8'(({1'b0, a} + {1'b0, b}) >> 1);
        res[F_PAETH] = x - paeth_pred(a, b, c);
    end

    assign push_ok = (r_op == OP_PUSH) && !r_row_ready;
    assign wp_next = {{(PW-AW){1'b0}}, r_pos} + PW'(1);

    always_comb begin
        logic [SUM_W:0] s;
        for (int f = 0; f < NUM_FILTERS; f++) begin
            s = (r_data_new ? {(SUM_W+1){1'b0}} : {1'b0, r_sum[f]})
                + (SUM_W+1)'(res[f]);
            n_sum[f] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
        end
    end

    always_comb begin
        best = F_NONE;
        for (int f = 1; f < NUM_FILTERS; f++) begin
            if (r_sum[f] < r_sum[best]) best = 3'(f);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= RB_RESET;
            r_bpp <= BPP_RESET;
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROW_BYTES: r_row_bytes <= i_cfg_wdata[PW-1:0];
                CFG_BPP: r_bpp <= i_cfg_wdata[3:0];
                CFG_THRESHOLD: r_thr <= i_cfg_wdata;
                default: r_thr <= r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            for (int f = 0; f < NUM_FILTERS; f++) r_sum[f] <= '0;
            r_chosen <= F_NONE;
            r_row_ready <= 1'b0;
            r_first <= 1'b1;
            r_bank <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.exec) begin
                if (r_op == OP_PUSH) begin
                    r_o_byte <= '0;
                    r_o_flags <= {r_row_ready, 2'b00};
                    r_o_last <= 1'b0;
                    if (!r_row_ready) begin
                        if (r_data_new) r_first <= 1'b1;
                        for (int f = 0; f < NUM_FILTERS; f++) r_sum[f] <= n_sum[f];
                        r_wp <= wp_next;
                        if (wp_next >= len) r_rp <= '0;
                    end
                end else if (r_row_ready) begin
                    if (r_rp == '0) begin
                        r_o_byte <= {5'd0, r_chosen};
                        r_o_flags <= 3'b011;
                        r_o_last <= 1'b0;
                        r_rp <= PW'(1);
                    end else begin
                        r_o_byte <= res[r_chosen];
                        r_o_flags <= 3'b010;
                        r_o_last <= (r_rp >= len);
                        if (r_rp >= len) begin
                            r_bank <= ~r_bank;
                            r_row_ready <= 1'b0;
                            r_first <= 1'b0;
                            r_wp <= '0;
                            r_rp <= '0;
                            for (int f = 0; f < NUM_FILTERS; f++) r_sum[f] <= '0;
                        end else begin
                            r_rp <= r_rp + PW'(1);
                        end
                    end
                end else begin
                    r_o_byte <= '0;
                    r_o_flags <= '0;
                    r_o_last <= 1'b0;
                end
            end
            if (i_cmd.pick) begin
                if (r_first) begin
                    r_chosen <= ({3'd0, len} < r_thr) ? F_NONE : F_SUB;
                end else begin
                    r_chosen <= best;
                end
                r_row_ready <= 1'b1;
            end
        end
    end

    assign o_stat.out_free = !r_o_valid || i_out_ready;
    assign o_stat.row_done = push_ok && (wp_next >= len);
    assign o_out_valid = r_o_valid;
    assign o_out_byte = r_o_byte;
    assign o_out_flags = r_o_flags;
    assign o_out_last = r_o_last;

    a_ready_by_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_row_ready) |-> $past(i_cmd.pick))
        else $error("row ready without pick");
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= PW'(MAX_ROW_BYTES))
        else $error("write position out of range");
    a_chosen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chosen <= F_PAETH)
        else $error("bad filter code");
endmodule
`default_nettype wire

FILE: hw/rtl/png_row_filter_selector.sv
// Top level of the PNG row filter selector: controller plus datapath.
// Depends on prfs_pkg, prfs_ctrl and prfs_dp.
//
// Each beat is a push of one raw byte or a pull of one output byte, and each
// beat returns exactly one result beat. A beat is a row store read, then a
// residual and sum update; the push that ends a row is also followed by the
// minimum-sum filter pick. The two row stores are banks that swap roles
// when a row is fully drained, so no copy pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module png_row_filter_selector (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,   // data_byte
    input  wire logic [1:0]     s_axis_tuser,   // operation, new_image
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // out_byte
    output logic [2:0]          m_axis_tuser,   // is_type_byte, out_valid, push_refused
    output logic                m_axis_tlast,   // last_of_row
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_addr,
    input  wire logic [15:0]    i_cfg_wdata
);
    import prfs_pkg::*;

    t_cmd cmd;
    t_stat stat;

    prfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    prfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (s_axis_tuser[0]),
        .i_data      (s_axis_tdata),
        .i_new       (s_axis_tuser[1]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_flags (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );
endmodule
`default_nettype wire

FILE: tb/prfs_row_checker.sv
// Watches the stream, config and result channels of png_row_filter_selector and
// predicts every result beat from its own row stores and filter sums.
// Depends on prfs_pkg for register indexes, filter codes and operation codes.
`timescale 1ns / 1ps
`default_nettype none
module prfs_row_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // data_byte
    input  wire logic [1:0]  i_s_tuser,    // operation, new_image
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  i_m_tdata,    // out_byte
    input  wire logic [2:0]  i_m_tuser,    // is_type_byte, out_valid, push_refused
    input  wire logic        i_m_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    output int               o_pending,
    output int               o_errors
);
    import prfs_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_type;
        logic       last;
        logic       valid;
        logic       refused;
    } t_filtered;

    localparam int SUM_SAT = (1 << SUM_W) - 1;

    logic [7:0]  cur_row [MAX_ROW_BYTES];
    logic [7:0]  above_row [MAX_ROW_BYTES];
    int          wr_pos;
    int          rd_pos;
    int          sums [NUM_FILTERS];
    logic [2:0]  pick;
    bit          ready;
    bit          first_row;
    logic [12:0] rb_reg;
    logic [3:0]  bpp_reg;
    logic [15:0] thr_reg;
    t_filtered   filtered_q[$];
    int          errors;

    assign o_pending = filtered_q.size();
    assign o_errors  = errors;

    function automatic int row_len();
        if (rb_reg == 0) return 1;
        if (rb_reg > MAX_ROW_BYTES) return MAX_ROW_BYTES;
        return int'(rb_reg);
    endfunction

    function automatic int pix_dist();
        if (bpp_reg == 0) return 1;
        if (bpp_reg > MAX_BPP) return MAX_BPP;
        return int'(bpp_reg);
    endfunction

    function automatic int paeth_of(input int a, input int b, input int c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    function automatic logic [7:0] residue(input logic [2:0] f, input int pos);
        int x;
        int a;
        int b;
        int c;
        int pr;
        int d;
        a = 0;
        c = 0;
        d = pix_dist();
        if (pos >= MAX_ROW_BYTES) pos = MAX_ROW_BYTES - 1;
        x = cur_row[pos];
        b = above_row[pos];
        if (pos >= d) begin
            a = cur_row[pos - d];
            c = above_row[pos - d];
        end
        case (f)
            F_SUB:   pr = a;
            F_UP:    pr = b;
            F_AVG:   pr = (a + b) >> 1;
            F_PAETH: pr = paeth_of(a, b, c);
            default: pr = 0;
        endcase
        return 8'(x - pr);
    endfunction

    task automatic filter_row_beat(input logic op, input logic [7:0] d, input logic ni);
        t_filtered r;
        int len;
        int s;
        int best;
        r = '0;
        len = row_len();
        if (op == OP_PUSH) begin
            if (ready) begin
                r.refused = 1'b1;
            end else begin
                if (ni) begin
                    wr_pos = 0;
                    for (int f = 0; f < NUM_FILTERS; f++) sums[f] = 0;
                    first_row = 1'b1;
                end
                if (wr_pos >= MAX_ROW_BYTES) wr_pos = MAX_ROW_BYTES - 1;
                cur_row[wr_pos] = d;
                for (int f = 0; f < NUM_FILTERS; f++) begin
                    s = sums[f] + int'(residue(3'(f), wr_pos));
                    sums[f] = (s > SUM_SAT) ? SUM_SAT : s;
                end
                wr_pos++;
                if (wr_pos >= len) begin
                    if (first_row) begin
                        pick = (len < int'(thr_reg)) ? F_NONE : F_SUB;
                    end else begin
                        best = 0;
                        for (int f = 1; f < NUM_FILTERS; f++)
                            if (sums[f] < sums[best]) best = f;
                        pick = 3'(best);
                    end
                    ready = 1'b1;
                    rd_pos = 0;
                end
            end
        end else if (ready) begin
            r.valid = 1'b1;
            if (rd_pos == 0) begin
                r.out_byte = {5'd0, pick};
                r.is_type = 1'b1;
                rd_pos = 1;
            end else begin
                r.out_byte = residue(pick, rd_pos - 1);
                if (rd_pos >= len) begin
                    r.last = 1'b1;
                    above_row = cur_row;
                    ready = 1'b0;
                    first_row = 1'b0;
                    wr_pos = 0;
                    rd_pos = 0;
                    for (int f = 0; f < NUM_FILTERS; f++) sums[f] = 0;
                end else begin
                    rd_pos++;
                end
            end
        end
        filtered_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_filtered got;
        t_filtered want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ROW_BYTES; i++) begin
                cur_row[i] = '0;
                above_row[i] = '0;
            end
            wr_pos = 0;
            rd_pos = 0;
            for (int f = 0; f < NUM_FILTERS; f++) sums[f] = 0;
            pick = F_NONE;
            ready = 1'b0;
            first_row = 1'b1;
            rb_reg = 13'(RB_RESET);
            bpp_reg = BPP_RESET;
            thr_reg = THR_RESET;
            filtered_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ROW_BYTES: rb_reg = i_cfg_wdata[12:0];
                    CFG_BPP:       bpp_reg = i_cfg_wdata[3:0];
                    CFG_THRESHOLD: thr_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata, i_m_tuser[0], i_m_tlast, i_m_tuser[1], i_m_tuser[2]};
                if (filtered_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result beat byte=%h user=%b last=%b",
                                 $realtime, i_m_tdata, i_m_tuser, i_m_tlast);
                end else begin
                    want = filtered_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.is_type !== want.is_type ||
                        got.last !== want.last || got.valid !== want.valid ||
                        got.refused !== want.refused) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch exp byte=%h type=%b last=%b valid=%b ",
                                      "refused=%b got byte=%h type=%b last=%b valid=%b ",
                                      "refused=%b"}, $realtime, want.out_byte, want.is_type,
                                     want.last, want.valid, want.refused, got.out_byte,
                                     got.is_type, got.last, got.valid, got.refused);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                filter_row_beat(i_s_tuser[0], i_s_tdata, i_s_tuser[1]);
        end
    end
endmodule
`default_nettype wire

FILE: tb/png_row_filter_selector_test.sv
// Top of the png_row_filter_selector bench: clock, reset, push/pull stimulus,
// receiver stalls and the verdict. Depends on prfs_pkg, png_row_filter_selector and prfs_row_checker.
`timescale 1ns / 1ps
`default_nettype none
module png_row_filter_selector_test;
    import prfs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    int          pending;
    int          errors;
    int          idle_pct;
    int          stall_pct;
    int          hold_left;
    int          cycles;
    int          beats;
    int          eff_len;

    png_row_filter_selector u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    prfs_row_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .o_pending(pending), .o_errors(errors)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic beat(input logic op, input logic [7:0] d, input logic ni);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= {ni, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        beats++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROW_BYTES)
            eff_len = (v[12:0] == 0) ? 1 : (v[12:0] > MAX_ROW_BYTES) ? MAX_ROW_BYTES
                                                                     : int'(v[12:0]);
    endtask

    // push one row, then pull it out; noise adds empty pulls and refused pushes
    task automatic push_pull_row(input bit start_img, input int noise);
        int j;
        j = 0;
        while (j < eff_len) begin
            if ($urandom_range(99) < noise)
                beat(OP_PULL, 8'($urandom), 1'($urandom));
            if (j > 0 && $urandom_range(199) == 0) begin
                beat(OP_PUSH, 8'($urandom), 1'b1);
                j = 1;
            end else begin
                beat(OP_PUSH, 8'($urandom), (j == 0) && start_img);
                j++;
            end
        end
        if ($urandom_range(99) < noise)
            beat(OP_PUSH, 8'($urandom), 1'($urandom));
        for (int k = 0; k <= eff_len; k++)
            beat(OP_PULL, 8'($urandom), 1'($urandom));
    endtask

    task automatic random_phase(input int idle, input int stall, input int n);
        int target;
        int len;
        idle_pct = idle;
        stall_pct = stall;
        target = beats + n;
        while (beats < target) begin
            case ($urandom_range(9))
                0:       len = $urandom_range(0, 64);
                1:       len = $urandom_range(13, 40);
                default: len = $urandom_range(1, 12);
            endcase
            set_reg(CFG_ROW_BYTES, 16'(len));
            set_reg(CFG_BPP, 16'($urandom_range(0, 15)));
            case ($urandom_range(3))
                0:       set_reg(CFG_THRESHOLD, 16'd0);
                1:       set_reg(CFG_THRESHOLD, 16'hFFFF);
                default: set_reg(CFG_THRESHOLD, 16'($urandom_range(0, 16)));
            endcase
            idle_pct = idle;
            push_pull_row(1'b1, 8);
            repeat ($urandom_range(2, 8)) begin
                if (beats >= target) break;
                push_pull_row($urandom_range(9) == 0, 8);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_ROW_BYTES;
        cfg_wdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        cycles = 0;
        beats = 0;
        eff_len = MAX_ROW_BYTES;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_reg(CFG_ROW_BYTES, 16'd4);
        set_reg(CFG_BPP, 16'd1);
        set_reg(CFG_THRESHOLD, 16'd0);
        beat(OP_PULL, 8'h00, 1'b1);
        beat(OP_PUSH, 8'h00, 1'b1);
        beat(OP_PUSH, 8'hFF, 1'b0);
        beat(OP_PUSH, 8'h00, 1'b0);
        beat(OP_PUSH, 8'hFF, 1'b0);
        beat(OP_PUSH, 8'hAA, 1'b1);
        repeat (5) beat(OP_PULL, 8'hFF, 1'b1);
        beat(OP_PUSH, 8'hFF, 1'b0);
        beat(OP_PUSH, 8'h00, 1'b0);
        beat(OP_PUSH, 8'h80, 1'b0);
        beat(OP_PUSH, 8'h01, 1'b0);
        repeat (5) beat(OP_PULL, 8'h00, 1'b0);

        // shrink the row while it is partly loaded
        set_reg(CFG_ROW_BYTES, 16'd8);
        beat(OP_PUSH, 8'h10, 1'b1);
        repeat (4) beat(OP_PUSH, 8'($urandom), 1'b0);
        set_reg(CFG_ROW_BYTES, 16'd2);
        beat(OP_PUSH, 8'h7F, 1'b0);
        repeat (3) beat(OP_PULL, 8'h00, 1'b0);
        set_reg(CFG_ROW_BYTES, 16'd0);
        set_reg(CFG_BPP, 16'd0);
        set_reg(CFG_THRESHOLD, 16'hFFFF);
        push_pull_row(1'b0, 0);
        set_reg(CFG_ROW_BYTES, 16'd16);
        set_reg(CFG_BPP, 16'd15);
        push_pull_row(1'b1, 0);
        push_pull_row(1'b0, 0);

        // longer rows; hold the receiver off so that pushes wait on the unread result
        set_reg(CFG_ROW_BYTES, 16'd48);
        set_reg(CFG_BPP, 16'd8);
        hold_left = 400;
        push_pull_row(1'b1, 0);
        push_pull_row(1'b0, 0);

        random_phase(0, 0, 400);
        random_phase(52, 0, 400);
        random_phase(0, 52, 400);
        random_phase(6, 6, 400);
        hold_left = 300;
        random_phase(0, 0, 100);

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/prfs_pkg.sv
hw/rtl/prfs_ctrl.sv
hw/rtl/prfs_dp.sv
hw/rtl/png_row_filter_selector.sv
tb/prfs_row_checker.sv
tb/png_row_filter_selector_test.sv
